### sv/cigar_to_variant_events_defines.svh
// Assertion macros used by the top module of the variant event block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CIGAR_TO_VARIANT_EVENTS_DEFINES_SVH
`define CIGAR_TO_VARIANT_EVENTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cve_pkg.sv
`default_nettype none

package cve_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int FIELD_BITS   = 32;
    localparam int OP_BITS      = 3;
    localparam int KIND_BITS    = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [OP_BITS-1:0] OP_MATCH    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_MISMATCH = 3'd1;
    localparam logic [OP_BITS-1:0] OP_INSERT   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DELETE   = 3'd3;

    localparam logic [KIND_BITS-1:0] KIND_EVENT   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_OVERRUN = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CONTIG  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_DONE    = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_LENGTH = 1'd1;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] var_pos;
        logic [FIELD_BITS-1:0] ref_len;
        logic [FIELD_BITS-1:0] alt_start;
        logic [FIELD_BITS-1:0] alt_len;
        logic                  run_end;
    } res_t;

    typedef struct packed {
        logic diff_open;
        logic discarding;
    } ctrl_t;

endpackage

`default_nettype wire

### sv/cve_op_if.sv
`default_nettype none

interface cve_op_if;
    logic                           valid;
    logic                           ready;
    logic [cve_pkg::OP_BITS-1:0]    op_code;
    logic [cve_pkg::FIELD_BITS-1:0] run_length;
    logic                           last_op;

    modport source (output valid, output op_code, output run_length, output last_op,
                    input ready);
    modport sink (input valid, input op_code, input run_length, input last_op,
                  output ready);
endinterface

`default_nettype wire

### sv/cve_evt_if.sv
`default_nettype none

interface cve_evt_if;
    logic                           valid;
    logic                           ready;
    logic [cve_pkg::KIND_BITS-1:0]  kind;
    logic [cve_pkg::FIELD_BITS-1:0] var_pos;
    logic [cve_pkg::FIELD_BITS-1:0] ref_len;
    logic [cve_pkg::FIELD_BITS-1:0] alt_start;
    logic [cve_pkg::FIELD_BITS-1:0] alt_len;
    logic                           run_end;

    modport source (output valid, output kind, output var_pos, output ref_len,
                    output alt_start, output alt_len, output run_end, input ready);
    modport sink (input valid, input kind, input var_pos, input ref_len,
                  input alt_start, input alt_len, input run_end, output ready);
endinterface

`default_nettype wire

### sv/cve_step.sv
`default_nettype none

// Combinational update for one alignment operation: advances the positions,
// opens or closes the diff stretch and forms up to two results.
module cve_step #(
    parameter int POS_BITS = cve_pkg::POS_BITS_DEF
) (
    input  wire logic [cve_pkg::OP_BITS-1:0]                                op_code,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS)-1:0]                         run_length,
    input  wire logic                                                       last_op,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS):0]                           q_pos,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS):0]                           t_pos,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS)-1:0]                         q_start,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS)-1:0]                         t_start,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS)-1:0]                         q_len,
    input  wire logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                        : cve_pkg::FIELD_BITS)-1:0]                         t_len,
    input  wire cve_pkg::ctrl_t                                             ctrl,
    output logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                   : cve_pkg::FIELD_BITS):0]                                q_pos_next,
    output logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                   : cve_pkg::FIELD_BITS):0]                                t_pos_next,
    output logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                   : cve_pkg::FIELD_BITS)-1:0]                              q_start_next,
    output logic [((POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                   : cve_pkg::FIELD_BITS)-1:0]                              t_start_next,
    output cve_pkg::ctrl_t                                                  ctrl_next,
    output cve_pkg::res_t                                                   res0,
    output cve_pkg::res_t                                                   res1,
    output logic [1:0]                                                      n_res
);

    localparam int LEN_BITS = (POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                              : cve_pkg::FIELD_BITS;

    logic                is_match;
    logic                adv_q;
    logic                adv_t;
    logic                opening;
    logic [LEN_BITS-1:0] q_st;
    logic [LEN_BITS-1:0] t_st;
    logic [LEN_BITS:0]   q_new;
    logic [LEN_BITS:0]   t_new;
    logic                overrun;
    logic [LEN_BITS:0]   q_cl;
    logic [LEN_BITS:0]   t_cl;
    logic                at_origin;
    logic                cl_err;
    logic [LEN_BITS:0]   t_span1;
    logic [LEN_BITS:0]   q_span1;
    logic [LEN_BITS-1:0] t_st_m1;
    logic [LEN_BITS-1:0] q_st_m1;
    cve_pkg::res_t       ev_res;
    cve_pkg::res_t       ovr_res;
    cve_pkg::res_t       ctg_res;
    cve_pkg::res_t       done_res;
    logic                err;
    logic                clear;

    always_comb
    begin
        is_match = (op_code == cve_pkg::OP_MATCH);
        adv_q    = op_code inside {cve_pkg::OP_MATCH, cve_pkg::OP_MISMATCH, cve_pkg::OP_INSERT};
        adv_t    = op_code inside {cve_pkg::OP_MATCH, cve_pkg::OP_MISMATCH, cve_pkg::OP_DELETE};
        opening  = !is_match && !ctrl.diff_open;
        q_st     = opening ? q_pos[LEN_BITS-1:0] : q_start;
        t_st     = opening ? t_pos[LEN_BITS-1:0] : t_start;

        q_new    = q_pos + (adv_q ? {1'b0, run_length} : '0);
        t_new    = t_pos + (adv_t ? {1'b0, run_length} : '0);
        overrun  = (q_new > {1'b0, q_len}) || (t_new > {1'b0, t_len});

        // A match closes the stretch before it advances; the last operation
        // closes it after advancing.
        q_cl      = is_match ? q_pos : q_new;
        t_cl      = is_match ? t_pos : t_new;
        at_origin = (t_st == '0);
        cl_err    = at_origin ? ((t_cl >= {1'b0, t_len}) || (q_cl >= {1'b0, q_len}))
                              : (q_st == '0);
        t_span1   = t_cl - {1'b0, t_st} + 1'b1;
        q_span1   = q_cl - {1'b0, q_st} + 1'b1;
        t_st_m1   = t_st - 1'b1;
        q_st_m1   = q_st - 1'b1;
    end

    always_comb
    begin
        ev_res.kind      = cve_pkg::KIND_EVENT;
        ev_res.var_pos   = at_origin ? '0 : cve_pkg::FIELD_BITS'(t_st_m1);
        ev_res.ref_len   = cve_pkg::FIELD_BITS'(t_span1);
        ev_res.alt_start = at_origin ? cve_pkg::FIELD_BITS'(q_st)
                                     : cve_pkg::FIELD_BITS'(q_st_m1);
        ev_res.alt_len   = cve_pkg::FIELD_BITS'(q_span1);
        ev_res.run_end   = 1'b0;

        ovr_res          = '0;
        ovr_res.kind     = cve_pkg::KIND_OVERRUN;
        ctg_res          = '0;
        ctg_res.kind     = cve_pkg::KIND_CONTIG;
        done_res         = '0;
        done_res.kind    = cve_pkg::KIND_DONE;
    end

    always_comb
    begin
        res0  = ev_res;
        res1  = done_res;
        n_res = 2'd0;
        err   = 1'b0;
        clear = 1'b0;

        if (ctrl.discarding)
        begin
            clear = last_op;
        end
        else if (is_match && ctrl.diff_open)
        begin
            if (cl_err)
            begin
                res0  = ctg_res;
                n_res = 2'd1;
                err   = 1'b1;
            end
            else if (overrun)
            begin
                res1  = ovr_res;
                n_res = 2'd2;
                err   = 1'b1;
            end
            else if (last_op)
            begin
                n_res = 2'd2;
                clear = 1'b1;
            end
            else
            begin
                n_res = 2'd1;
            end
        end
        else if (overrun)
        begin
            res0  = ovr_res;
            n_res = 2'd1;
            err   = 1'b1;
        end
        else if (last_op)
        begin
            if (!is_match)
            begin
                if (cl_err)
                begin
                    res0  = ctg_res;
                    n_res = 2'd1;
                    err   = 1'b1;
                end
                else
                begin
                    n_res = 2'd2;
                    clear = 1'b1;
                end
            end
            else
            begin
                res0  = done_res;
                n_res = 2'd1;
                clear = 1'b1;
            end
        end

        res0.run_end = (n_res == 2'd1);
        res1.run_end = 1'b1;

        if (err && last_op)
        begin
            clear = 1'b1;
        end
    end

    always_comb
    begin
        if (clear)
        begin
            q_pos_next   = '0;
            t_pos_next   = '0;
            q_start_next = '0;
            t_start_next = '0;
            ctrl_next    = '0;
        end
        else if (ctrl.discarding)
        begin
            q_pos_next   = q_pos;
            t_pos_next   = t_pos;
            q_start_next = q_start;
            t_start_next = t_start;
            ctrl_next    = ctrl;
        end
        else
        begin
            q_pos_next           = q_new;
            t_pos_next           = t_new;
            q_start_next         = q_st;
            t_start_next         = t_st;
            ctrl_next.diff_open  = !is_match;
            ctrl_next.discarding = err;
        end
    end

endmodule

`default_nettype wire

### sv/cigar_to_variant_events.sv
`default_nettype none

// Turns a stream of alignment operations into variant events. Each transfer
// on ops carries one operation; each stretch of non-match operations becomes
// one event on events, followed by a done result after the last operation,
// or an error result after which operations are dropped up to the last one.
// An operation enters an input register and is resolved combinationally into
// a two-entry result register, waiting while that register has no room for
// its results. One operation is taken every cycle while each yields at most
// one result and the sink keeps up; an operation that yields two results
// (an event plus done or overrun) holds the result register until both have
// left, since results leave one per cycle while the sink is ready. Operations
// that yield no result never wait for the output. Program query_length and
// target_length before the first operation of an alignment.
module cigar_to_variant_events #(
    parameter int POS_BITS = cve_pkg::POS_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    cve_op_if.sink                                 ops,
    cve_evt_if.source                              events,
    input  wire logic                              cfg_we,
    input  wire logic [cve_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cve_pkg::FIELD_BITS-1:0]    cfg_data
);

`include "cigar_to_variant_events_defines.svh"

    localparam int LEN_BITS = (POS_BITS < cve_pkg::FIELD_BITS) ? POS_BITS
                              : cve_pkg::FIELD_BITS;

    logic [LEN_BITS-1:0]          q_len_reg;
    logic [LEN_BITS-1:0]          t_len_reg;

    logic                         in_vld_reg;
    logic [cve_pkg::OP_BITS-1:0]  in_op_reg;
    logic [LEN_BITS-1:0]          in_run_reg;
    logic                         in_last_reg;

    logic [LEN_BITS:0]            q_pos_reg;
    logic [LEN_BITS:0]            t_pos_reg;
    logic [LEN_BITS-1:0]          q_start_reg;
    logic [LEN_BITS-1:0]          t_start_reg;
    cve_pkg::ctrl_t               ctrl_reg;

    logic [LEN_BITS:0]            q_pos_next;
    logic [LEN_BITS:0]            t_pos_next;
    logic [LEN_BITS-1:0]          q_start_next;
    logic [LEN_BITS-1:0]          t_start_next;
    cve_pkg::ctrl_t               ctrl_next;
    cve_pkg::res_t                step_res0;
    cve_pkg::res_t                step_res1;
    logic [1:0]                   step_n;

    cve_pkg::res_t                slot_reg [2];
    cve_pkg::res_t                slot_next [2];
    logic [1:0]                   cnt_reg;
    logic [1:0]                   cnt_next;

    logic                         out_tx;
    logic                         room;
    logic                         proc_fire;

    cve_step #(
        .POS_BITS (POS_BITS)
    ) u_step (
        .op_code      (in_op_reg),
        .run_length   (in_run_reg),
        .last_op      (in_last_reg),
        .q_pos        (q_pos_reg),
        .t_pos        (t_pos_reg),
        .q_start      (q_start_reg),
        .t_start      (t_start_reg),
        .q_len        (q_len_reg),
        .t_len        (t_len_reg),
        .ctrl         (ctrl_reg),
        .q_pos_next   (q_pos_next),
        .t_pos_next   (t_pos_next),
        .q_start_next (q_start_next),
        .t_start_next (t_start_next),
        .ctrl_next    (ctrl_next),
        .res0         (step_res0),
        .res1         (step_res1),
        .n_res        (step_n)
    );

    // The results of an operation are written only into an empty result
    // register, or one whose single entry leaves in this cycle.
    assign out_tx    = events.valid && events.ready;
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_tx);
    assign proc_fire = in_vld_reg && ((step_n == 2'd0) || room);
    assign ops.ready = !in_vld_reg || proc_fire;

    assign events.valid     = (cnt_reg != 2'd0);
    assign events.kind      = slot_reg[0].kind;
    assign events.var_pos   = slot_reg[0].var_pos;
    assign events.ref_len   = slot_reg[0].ref_len;
    assign events.alt_start = slot_reg[0].alt_start;
    assign events.alt_len   = slot_reg[0].alt_len;
    assign events.run_end   = slot_reg[0].run_end;

    always_comb
    begin
        cnt_next     = cnt_reg;
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (proc_fire && (step_n != 2'd0))
        begin
            cnt_next     = step_n;
            slot_next[0] = step_res0;
            slot_next[1] = step_res1;
        end
        else if (out_tx)
        begin
            cnt_next     = cnt_reg - 1'b1;
            slot_next[0] = slot_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_len_reg   <= '0;
            t_len_reg   <= '0;
            in_vld_reg  <= 1'b0;
            q_pos_reg   <= '0;
            t_pos_reg   <= '0;
            q_start_reg <= '0;
            t_start_reg <= '0;
            ctrl_reg    <= '0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cve_pkg::CFG_QUERY_LENGTH:  q_len_reg <= cfg_data[LEN_BITS-1:0];
                    cve_pkg::CFG_TARGET_LENGTH: t_len_reg <= cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (ops.ready)
            begin
                in_vld_reg <= ops.valid;
            end
            if (proc_fire)
            begin
                q_pos_reg   <= q_pos_next;
                t_pos_reg   <= t_pos_next;
                q_start_reg <= q_start_next;
                t_start_reg <= t_start_next;
                ctrl_reg    <= ctrl_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.valid && ops.ready)
        begin
            in_op_reg   <= ops.op_code;
            in_run_reg  <= ops.run_length[LEN_BITS-1:0];
            in_last_reg <= ops.last_op;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    `CVE_ASSERT_NOW(a_fill_only_when_drained, proc_fire && (step_n != 2'd0),
                    (cnt_reg == 2'd0) || out_tx, "results written over pending results")
    `CVE_ASSERT_NOW(a_pair_head_not_end, cnt_reg == 2'd2, !slot_reg[0].run_end,
                    "first of two pending results marked as the end of its run")
    `CVE_ASSERT_NOW(a_start_behind_pos, ctrl_reg.diff_open && !ctrl_reg.discarding,
                    ({1'b0, q_start_reg} <= q_pos_reg) && ({1'b0, t_start_reg} <= t_pos_reg),
                    "open event starts beyond the running positions")
    `CVE_ASSERT_NEXT(a_discard_ends_at_last,
                     proc_fire && ctrl_reg.discarding && in_last_reg,
                     !ctrl_reg.discarding && (q_pos_reg == '0) && (t_pos_reg == '0),
                     "alignment not cleared after the last discarded operation")

endmodule

`default_nettype wire

### verif/tb_cigar_to_variant_events.sv
module tb_cigar_to_variant_events;

    localparam logic [cve_pkg::OP_BITS-1:0] OP_OTHER     = 3'd4;
    // Codes above OP_OTHER are not defined and must behave like it.
    localparam logic [cve_pkg::OP_BITS-1:0] OP_LAST_CODE = 3'd7;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          HOLD_AFTER_OPS = 200;
    localparam int          PHASE_OPS      = 115;
    localparam int          TIMEOUT        = 4_000_000;

    typedef struct packed {
        logic [cve_pkg::OP_BITS-1:0]    op;
        logic [cve_pkg::FIELD_BITS-1:0] run;
        logic                           last;
    } op_item_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [cve_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [cve_pkg::FIELD_BITS-1:0]   cfg_data;

    cve_op_if  op_ch();
    cve_evt_if evt_ch();

    cigar_to_variant_events DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .ops       (op_ch),
        .events    (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    op_item_t      op_backlog[$];
    cve_pkg::res_t awaited_results[$];
    cve_pkg::res_t want;
    int unsigned   src_gap;
    int unsigned   sink_stall;
    bit            src_idle_on;
    bit            sink_stall_on;
    bit            sink_hold;
    int            ops_taken;
    int            results_seen;
    int            mismatches;
    int            kind_count[4];

    // Alignment tracker state and its copy of the length registers.
    bit [31:0] qlen_cfg;
    bit [31:0] tlen_cfg;
    bit [32:0] q_pos;
    bit [32:0] t_pos;
    bit [32:0] diff_q0;
    bit [32:0] diff_t0;
    bit        in_diff;
    bit        dropping;

    function automatic void add_result(logic [cve_pkg::KIND_BITS-1:0] kind, logic [31:0] pos,
                                       logic [31:0] rlen, logic [31:0] astart,
                                       logic [31:0] alen);
        cve_pkg::res_t r;
        r.kind      = kind;
        r.var_pos   = pos;
        r.ref_len   = rlen;
        r.alt_start = astart;
        r.alt_len   = alen;
        r.run_end   = 1'b0;
        awaited_results.push_back(r);
    endfunction

    function automatic void restart_alignment();
        q_pos    = '0;
        t_pos    = '0;
        in_diff  = 1'b0;
        diff_q0  = '0;
        diff_t0  = '0;
        dropping = 1'b0;
    endfunction

    // Closes the open diff stretch; returns 1 when it turns out to be an error.
    function automatic bit close_diff();
        bit [32:0] qspan;
        bit [32:0] tspan;
        qspan   = q_pos - diff_q0;
        tspan   = t_pos - diff_t0;
        in_diff = 1'b0;
        if (diff_t0 == 0)
        begin
            if (t_pos + 33'd1 > {1'b0, tlen_cfg} || q_pos + 33'd1 > {1'b0, qlen_cfg})
            begin
                add_result(cve_pkg::KIND_CONTIG, '0, '0, '0, '0);
                return 1'b1;
            end
            add_result(cve_pkg::KIND_EVENT, '0, 32'(tspan + 33'd1), diff_q0[31:0],
                       32'(qspan + 33'd1));
            return 1'b0;
        end
        // A stretch past the target start with no query base before it has no anchor.
        if (diff_q0 == 0)
        begin
            add_result(cve_pkg::KIND_CONTIG, '0, '0, '0, '0);
            return 1'b1;
        end
        add_result(cve_pkg::KIND_EVENT, 32'(diff_t0 - 33'd1), 32'(tspan + 33'd1),
                   32'(diff_q0 - 33'd1), 32'(qspan + 33'd1));
        return 1'b0;
    endfunction

    function automatic void advance_alignment(logic [cve_pkg::OP_BITS-1:0] op,
                                              logic [31:0] run, logic last);
        bit            failed;
        int            n_before;
        cve_pkg::res_t r;
        failed   = 1'b0;
        n_before = awaited_results.size();
        if (dropping)
        begin
            if (last)
                restart_alignment();
            return;
        end
        if (op != cve_pkg::OP_MATCH && !in_diff)
        begin
            in_diff = 1'b1;
            diff_q0 = q_pos;
            diff_t0 = t_pos;
        end
        if (op == cve_pkg::OP_MATCH && in_diff)
            failed = close_diff();
        if (!failed)
        begin
            case (op)
                cve_pkg::OP_MATCH, cve_pkg::OP_MISMATCH:
                begin
                    q_pos = q_pos + {1'b0, run};
                    t_pos = t_pos + {1'b0, run};
                end
                cve_pkg::OP_INSERT: q_pos = q_pos + {1'b0, run};
                cve_pkg::OP_DELETE: t_pos = t_pos + {1'b0, run};
                default: ;
            endcase
            if (q_pos > {1'b0, qlen_cfg} || t_pos > {1'b0, tlen_cfg})
            begin
                add_result(cve_pkg::KIND_OVERRUN, '0, '0, '0, '0);
                failed = 1'b1;
            end
        end
        if (!failed && last)
        begin
            if (in_diff)
                failed = close_diff();
            if (!failed)
            begin
                add_result(cve_pkg::KIND_DONE, '0, '0, '0, '0);
                restart_alignment();
            end
        end
        if (failed)
        begin
            if (last)
                restart_alignment();
            else
                dropping = 1'b1;
        end
        if (awaited_results.size() > n_before)
        begin
            r = awaited_results.pop_back();
            r.run_end = 1'b1;
            awaited_results.push_back(r);
        end
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_op(logic [cve_pkg::OP_BITS-1:0] op, logic [31:0] run,
                                    logic last);
        op_item_t it;
        it.op   = op;
        it.run  = run;
        it.last = last;
        op_backlog.push_back(it);
    endfunction

    // Queues one alignment. Unless it is noisy, runs are clipped so that the
    // positions stay within the programmed lengths.
    function automatic int queue_alignment(bit [31:0] qlen, bit [31:0] tlen, bit noisy);
        int unsigned                 n_ops;
        int unsigned                 pick;
        bit [32:0]                   q;
        bit [32:0]                   t;
        bit [32:0]                   room;
        logic [cve_pkg::OP_BITS-1:0] op;
        bit [31:0]                   run;
        n_ops = $urandom_range(1, 10);
        q     = '0;
        t     = '0;
        for (int k = 0; k < n_ops; k++)
        begin
            pick = $urandom_range(0, 99);
            if (noisy)
                op = cve_pkg::OP_BITS'($urandom_range(0, 7));
            else if (k == 0 && pick < 75)
                op = cve_pkg::OP_MATCH;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = cve_pkg::OP_MATCH;
                else if (pick < 58)
                    op = cve_pkg::OP_MISMATCH;
                else if (pick < 74)
                    op = cve_pkg::OP_INSERT;
                else if (pick < 90)
                    op = cve_pkg::OP_DELETE;
                else
                    op = cve_pkg::OP_BITS'($urandom_range(OP_OTHER, OP_LAST_CODE));
            end
            pick = $urandom_range(0, 99);
            if (noisy && pick < 50)
                run = $urandom();
            else if (pick < 8)
                run = 0;
            else if (pick < 90)
                run = $urandom_range(1, 8);
            else
                run = $urandom_range(9, 64);
            if (!noisy)
            begin
                room = {1'b1, ALL_ONES};
                if (op == cve_pkg::OP_MATCH || op == cve_pkg::OP_MISMATCH
                    || op == cve_pkg::OP_INSERT)
                    room = {1'b0, qlen} - q;
                if ((op == cve_pkg::OP_MATCH || op == cve_pkg::OP_MISMATCH
                     || op == cve_pkg::OP_DELETE) && {1'b0, tlen} - t < room)
                    room = {1'b0, tlen} - t;
                if ({1'b0, run} > room)
                    run = room[31:0];
            end
            if (op == cve_pkg::OP_MATCH || op == cve_pkg::OP_MISMATCH
                || op == cve_pkg::OP_INSERT)
                q = q + {1'b0, run};
            if (op == cve_pkg::OP_MATCH || op == cve_pkg::OP_MISMATCH
                || op == cve_pkg::OP_DELETE)
                t = t + {1'b0, run};
            push_op(op, run, k == n_ops - 1);
        end
        return n_ops;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (op_backlog.size() != 0 || op_ch.valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Waits until the block is idle, then programs both lengths.
    task automatic new_lengths(bit [31:0] qlen, bit [31:0] tlen);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= cve_pkg::CFG_QUERY_LENGTH;
        cfg_data  <= qlen;
        @(posedge clk);
        cfg_index <= cve_pkg::CFG_TARGET_LENGTH;
        cfg_data  <= tlen;
        @(posedge clk);
        cfg_we    <= 1'b0;
        qlen_cfg = qlen;
        tlen_cfg = tlen;
        @(negedge clk);
    endtask

    task automatic random_phase(bit [31:0] qlen, bit [31:0] tlen, bit with_idle);
        int queued;
        new_lengths(qlen, tlen);
        src_idle_on   = with_idle;
        sink_stall_on = with_idle;
        queued        = 0;
        while (queued < PHASE_OPS)
            queued += queue_alignment(qlen, tlen, $urandom_range(0, 99) < 15);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = cve_pkg::CFG_QUERY_LENGTH;
        cfg_data       = '0;
        op_ch.valid      = 1'b0;
        op_ch.op_code    = cve_pkg::OP_MATCH;
        op_ch.run_length = '0;
        op_ch.last_op    = 1'b0;
        evt_ch.ready     = 1'b0;
        sink_hold        = 1'b0;
        fork
            forever #4 clk = ~clk;
            begin
                repeat (3) @(posedge clk);
                rst_n <= 1'b1;
            end
        join
    end

    // Operation driver: a new transfer is offered once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_ch.valid <= 1'b0;
            src_gap     <= 0;
        end
        else if (!op_ch.valid || op_ch.ready)
        begin
            if (src_gap > 0)
            begin
                op_ch.valid <= 1'b0;
                src_gap     <= src_gap - 1;
            end
            else if (op_backlog.size() > 0)
            begin
                op_ch.op_code    <= op_backlog[0].op;
                op_ch.run_length <= op_backlog[0].run;
                op_ch.last_op    <= op_backlog[0].last;
                op_ch.valid      <= 1'b1;
                void'(op_backlog.pop_front());
                if (src_idle_on)
                    src_gap <= rand_gap();
            end
            else
                op_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_ch.ready <= 1'b0;
            sink_stall   <= 0;
        end
        else if (sink_hold)
            evt_ch.ready <= 1'b0;
        else if (sink_stall > 0)
        begin
            evt_ch.ready <= 1'b0;
            sink_stall   <= sink_stall - 1;
        end
        else
        begin
            evt_ch.ready <= 1'b1;
            if (sink_stall_on && ((evt_ch.valid && evt_ch.ready) || $urandom_range(0, 7) == 0))
                sink_stall <= rand_gap();
        end
    end

    // The output is held off for a long stretch so that the block backs up
    // and stalls its input while operations keep coming.
    initial
    begin
        wait (ops_taken >= HOLD_AFTER_OPS);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    function automatic void check_field(string name, logic [31:0] expected_val,
                                        logic [31:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name,
                     expected_val, actual_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (op_ch.valid && op_ch.ready)
            begin
                advance_alignment(op_ch.op_code, op_ch.run_length, op_ch.last_op);
                ops_taken++;
            end
            if (evt_ch.valid && evt_ch.ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual kind %0d",
                             $time, evt_ch.kind);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    kind_count[want.kind]++;
                    check_field("kind", 32'(want.kind), 32'(evt_ch.kind));
                    check_field("var_pos", want.var_pos, evt_ch.var_pos);
                    check_field("ref_len", want.ref_len, evt_ch.ref_len);
                    check_field("alt_start", want.alt_start, evt_ch.alt_start);
                    check_field("alt_len", want.alt_len, evt_ch.alt_len);
                    check_field("run_end", 32'(want.run_end), 32'(evt_ch.run_end));
                end
            end
        end
    end

    initial
    begin
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        wait (rst_n === 1'b1);

        // Zero lengths: an empty match finishes, a stretch at the target start fails.
        new_lengths(0, 0);
        push_op(cve_pkg::OP_MATCH, 0, 1'b1);
        push_op(cve_pkg::OP_MISMATCH, 0, 1'b1);

        new_lengths(50, 60);
        // Every defined code and two undefined ones, with insertion, deletion and other merged into one event.
        push_op(cve_pkg::OP_MATCH, 5, 1'b0);
        push_op(cve_pkg::OP_MISMATCH, 3, 1'b0);
        push_op(cve_pkg::OP_MATCH, 2, 1'b0);
        push_op(cve_pkg::OP_INSERT, 2, 1'b0);
        push_op(cve_pkg::OP_DELETE, 1, 1'b0);
        push_op(OP_OTHER, 0, 1'b0);
        push_op(OP_LAST_CODE, 1, 1'b0);
        push_op(cve_pkg::OP_MATCH, 4, 1'b1);
        // Event at the target start, closed by the end of the alignment.
        push_op(cve_pkg::OP_MISMATCH, 2, 1'b0);
        push_op(cve_pkg::OP_DELETE, 1, 1'b1);
        // Zero-length match keeps the query at its start, so the next stretch has no anchor base; the rest is dropped.
        push_op(cve_pkg::OP_DELETE, 3, 1'b0);
        push_op(cve_pkg::OP_MATCH, 0, 1'b0);
        push_op(cve_pkg::OP_MISMATCH, 1, 1'b0);
        push_op(cve_pkg::OP_MATCH, 1, 1'b0);
        push_op(cve_pkg::OP_INSERT, 1, 1'b1);
        // Stretch from the target start that reaches the end of the target.
        push_op(cve_pkg::OP_DELETE, 60, 1'b1);
        // Event closed and overrun by the same match, then dropping to the end.
        push_op(cve_pkg::OP_MATCH, 10, 1'b0);
        push_op(cve_pkg::OP_MISMATCH, 5, 1'b0);
        push_op(cve_pkg::OP_MATCH, 100, 1'b0);
        push_op(cve_pkg::OP_MATCH, 1, 1'b1);

        new_lengths(ALL_ONES, ALL_ONES);
        push_op(cve_pkg::OP_MATCH, ALL_ONES, 1'b0);
        push_op(cve_pkg::OP_MISMATCH, 0, 1'b1);
        push_op(cve_pkg::OP_INSERT, ALL_ONES, 1'b0);
        push_op(cve_pkg::OP_MATCH, 1, 1'b1);

        random_phase($urandom_range(40, 120), $urandom_range(40, 120), 1'b1);
        random_phase($urandom_range(200, 5000), $urandom_range(200, 5000), 1'b0);
        random_phase(ALL_ONES, ALL_ONES, 1'b1);
        random_phase($urandom(), $urandom(), 1'b1);
        random_phase($urandom_range(0, 3), $urandom_range(100, 300), 1'b1);

        wait_idle();
        $display("summary: %0d operations, %0d results (%0d events, %0d overruns, %0d contig,",
                 ops_taken, results_seen, kind_count[cve_pkg::KIND_EVENT],
                 kind_count[cve_pkg::KIND_OVERRUN], kind_count[cve_pkg::KIND_CONTIG]);
        $display("summary: %0d done), lengths from zero to all ones, one output hold of %0d cycles",
                 kind_count[cve_pkg::KIND_DONE], HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("tb: failure");
        $finish;
    end

endmodule
